/* hw/rtl/humidity_temp_frame_decoder_macros.svh */
// assertion macros for the humidity and temperature frame decoder
`ifndef HUMIDITY_TEMP_FRAME_DECODER_MACROS_SVH
`define HUMIDITY_TEMP_FRAME_DECODER_MACROS_SVH

`ifndef SYNTHESIS

// property checked on every rising edge outside reset
`define HTFD_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("htfd assertion failed");

// condition that must never be seen outside reset
`define HTFD_ASSERT_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("htfd forbidden condition seen");

`else

`define HTFD_ASSERT(lbl, prop)
`define HTFD_ASSERT_NEVER(lbl, cond)

`endif

`endif

/* hw/rtl/htfd_pkg.sv */
// shared constants, types and the crc-8 byte step for the frame decoder
`timescale 1ns / 1ps

package htfd_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned POS_W  = 3;
	localparam int unsigned DATA_W = 40;
	localparam int unsigned RAW_W  = 20;
	localparam int unsigned HUM_W  = 10;
	localparam int unsigned TEMP_W = 12;

	// byte position codes: index of the next expected byte, or idle
	localparam logic [POS_W-1:0] POS_FIRST_DATA = 3'd1;
	localparam logic [POS_W-1:0] POS_LAST_DATA  = 3'd5;
	localparam logic [POS_W-1:0] POS_CRC        = 3'd6;
	localparam logic [POS_W-1:0] POS_IDLE       = 3'd7;

	localparam logic [BYTE_W-1:0] CRC_INIT = 8'hFF;
	localparam logic [BYTE_W-1:0] CRC_POLY = 8'h31;

	// status handed from the frame tracker to the top level
	typedef struct packed {
		logic done;    // this request is the crc byte of a frame
		logic crc_ok;  // running crc equals this byte
	} frame_ctl_t;

	// one byte of crc-8, msb first, eight shift steps
	function automatic logic [BYTE_W-1:0] crc8_step(input logic [BYTE_W-1:0] crc,
		input logic [BYTE_W-1:0] b);
		logic [BYTE_W-1:0] c;
		c = crc ^ b;
		for (int k = 0; k < BYTE_W; k++) begin
			if (c[BYTE_W-1]) begin
				c = {c[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[BYTE_W-2:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

/* hw/rtl/humidity_temp_frame_decoder.sv */
// top level of the crc-checked humidity and temperature frame decoder
`timescale 1ns / 1ps

// Takes a 7-byte sensor frame one byte per request (status byte, five data
// bytes, crc byte); s_tuser high marks the status byte and restarts the
// frame. A crc-8 (poly 0x31, init 0xFF) runs over the first six bytes. On
// the crc byte one result leaves: humidity and temperature in tenths, both
// zero and m_tuser low when the crc does not match. Bytes outside a frame
// are dropped. One byte is taken every cycle unless a crc byte waits behind
// a result still held by the downstream side. A crc byte waits in the input
// register and its result is then caught in the result register. Only
// a result still held by the downstream side holds up a further crc byte.
module humidity_temp_frame_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tuser,   // [0] frame_start
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [9:0] humidity_tenths, [21:10] temperature_tenths, [23:22] zero
	output logic        m_tuser    // [0] crc_ok
);
	import htfd_pkg::*;

	`include "humidity_temp_frame_decoder_macros.svh"

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              start_s1;
	logic              advance;

	frame_ctl_t        ctl;
	logic [DATA_W-1:0] frame_data;
	logic [HUM_W-1:0]  hum_c;
	logic signed [TEMP_W-1:0] temp_c;

	logic                     res_valid_q;
	logic [HUM_W-1:0]         hum_q;
	logic signed [TEMP_W-1:0] temp_q;
	logic                     ok_q;

	// the waiting request moves on unless it yields a result that has no room
	assign advance  = valid_s1 && (!ctl.done || !res_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1  <= s_tdata;
			start_s1 <= s_tuser;
		end
	end

	htfd_frame_tracker u_tracker (
		.clk         (clk),
		.arst_n      (arst_n),
		.consume     (advance),
		.data_byte   (byte_s1),
		.frame_start (start_s1),
		.ctl         (ctl),
		.frame_data  (frame_data)
	);

	htfd_scale u_scale (
		.frame_data         (frame_data),
		.crc_ok             (ctl.crc_ok),
		.humidity_tenths    (hum_c),
		.temperature_tenths (temp_c)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance && ctl.done) begin
			res_valid_q <= 1'b1;
		end else if (m_tready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && ctl.done) begin
			hum_q  <= hum_c;
			temp_q <= temp_c;
			ok_q   <= ctl.crc_ok;
		end
	end

	assign m_tvalid = res_valid_q;
	assign m_tdata  = {2'b00, temp_q, hum_q};
	assign m_tuser  = ok_q;

	// checks on the result values
	`HTFD_ASSERT(a_fail_zero, m_tvalid && !m_tuser |-> m_tdata == 24'd0)
	`HTFD_ASSERT_NEVER(a_hum_range, m_tvalid && m_tdata[9:0] > 10'd999)
	`HTFD_ASSERT(a_temp_range, m_tvalid && m_tuser |-> $signed(m_tdata[21:10]) >= -12'sd500 && $signed(m_tdata[21:10]) <= 12'sd1499)

endmodule

/* hw/rtl/htfd_frame_tracker.sv */
// frame position counter, running crc and data byte store
`timescale 1ns / 1ps

module htfd_frame_tracker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          consume,
	input  logic [htfd_pkg::BYTE_W-1:0]   data_byte,
	input  logic                          frame_start,
	output htfd_pkg::frame_ctl_t          ctl,
	output logic [htfd_pkg::DATA_W-1:0]   frame_data
);
	import htfd_pkg::*;

	logic [POS_W-1:0]  pos_q;
	logic [BYTE_W-1:0] crc_q;
	logic [DATA_W-1:0] data_q;

	// classify the waiting request against the current position
	always_comb begin
		ctl.done   = !frame_start && (pos_q == POS_CRC);
		ctl.crc_ok = (crc_q == data_byte);
	end

	assign frame_data = data_q;

	// position and crc update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= POS_IDLE;
			crc_q <= CRC_INIT;
		end else if (consume) begin
			priority if (frame_start) begin
				crc_q <= crc8_step(CRC_INIT, data_byte);
				pos_q <= POS_FIRST_DATA;
			end else if (pos_q >= POS_FIRST_DATA && pos_q <= POS_LAST_DATA) begin
				crc_q <= crc8_step(crc_q, data_byte);
				pos_q <= pos_q + 3'd1;
			end else if (pos_q == POS_CRC) begin
				pos_q <= POS_IDLE;
			end else begin
				// idle, the byte is dropped
				pos_q <= pos_q;
			end
		end
	end

	// data bytes shift in, first data byte ends up highest
	always_ff @(posedge clk) begin
		if (consume && !frame_start && pos_q >= POS_FIRST_DATA && pos_q <= POS_LAST_DATA) begin
			data_q <= {data_q[DATA_W-BYTE_W-1:0], data_byte};
		end
	end

endmodule

/* hw/rtl/htfd_scale.sv */
// conversion of raw 20-bit readings to tenths of percent and degree
`timescale 1ns / 1ps

module htfd_scale (
	input  logic [htfd_pkg::DATA_W-1:0]        frame_data,
	input  logic                               crc_ok,
	output logic [htfd_pkg::HUM_W-1:0]         humidity_tenths,
	output logic signed [htfd_pkg::TEMP_W-1:0] temperature_tenths
);
	import htfd_pkg::*;

	localparam int unsigned HPROD_W = RAW_W + 10;
	localparam int unsigned TPROD_W = RAW_W + 11;
	localparam int unsigned TQ_W    = TPROD_W - RAW_W;

	logic [RAW_W-1:0]   raw_h;
	logic [RAW_W-1:0]   raw_t;
	logic [HPROD_W-1:0] hum_prod;
	logic [TPROD_W-1:0] temp_prod;
	logic [TQ_W-1:0]    temp_q11;

	// split the 40-bit word: humidity high, temperature low
	assign raw_h = frame_data[DATA_W-1:RAW_W];
	assign raw_t = frame_data[RAW_W-1:0];

	// constant multiplies, keep the top bits
	assign hum_prod  = {{(HPROD_W-RAW_W){1'b0}}, raw_h} * HPROD_W'(1000);
	assign temp_prod = {{(TPROD_W-RAW_W){1'b0}}, raw_t} * TPROD_W'(2000);
	assign temp_q11  = temp_prod[TPROD_W-1:RAW_W];

	// offset temperature, zero both on a bad crc
	always_comb begin
		if (crc_ok) begin
			humidity_tenths    = hum_prod[HPROD_W-1:RAW_W];
			temperature_tenths = $signed({1'b0, temp_q11} - TEMP_W'(500));
		end else begin
			humidity_tenths    = '0;
			temperature_tenths = '0;
		end
	end

endmodule

/* tb/sv/tb_humidity_temp_frame_decoder.sv */
// testbench for the crc-checked humidity and temperature frame decoder
`timescale 1ns / 1ps

// Bytes are sent as frames of a status byte, five data bytes and a crc byte.
// Some frames are broken, restarted or followed by stray bytes.
// A byte-level model of the decoder predicts each reading.
// Every reading that leaves the block is compared with the oldest prediction.
// The run uses three idling mixes on the two sides.
module tb_humidity_temp_frame_decoder;

	import htfd_pkg::*;

	// one decoded reading as it should leave the block
	typedef struct packed {
		logic [HUM_W-1:0]  hum;
		logic [TEMP_W-1:0] temp;
		logic              ok;
	} reading_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;   // [7:0] data_byte
	logic        s_tuser;   // [0] frame_start
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;   // [9:0] humidity_tenths, [21:10] temperature_tenths, [23:22] zero
	logic        m_tuser;   // [0] crc_ok

	int send_idle_pct;
	int recv_idle_pct;
	int errors;
	int bytes_used;
	int readings_seen;
	int frames_ok;
	int frames_bad;
	int restarts;

	// predicted readings still to arrive, oldest first
	reading_t readings_due[$];

	// decoder state as predicted
	logic [POS_W-1:0]  frame_pos;
	logic [BYTE_W-1:0] frame_crc;
	logic [DATA_W-1:0] frame_data;

	humidity_temp_frame_decoder dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// hard stop if the run hangs
	initial begin
		#2_000_000;
		$display("FAIL");
		$finish;
	end

	// crc-8 over one byte, one input bit at a time, msb first
	function automatic logic [BYTE_W-1:0] crc8_shift(input logic [BYTE_W-1:0] crc,
		input logic [BYTE_W-1:0] b);
		logic fb;
		for (int i = BYTE_W - 1; i >= 0; i--) begin
			fb  = crc[BYTE_W-1] ^ b[i];
			crc = {crc[BYTE_W-2:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
		end
		return crc;
	endfunction

	// advance the predicted decoder by one accepted byte; returns 0 if it is ignored
	function automatic logic decode_byte(input logic [7:0] b, input logic st);
		reading_t    r;
		logic [31:0] hprod;
		logic [31:0] tprod;
		int          t;
		if (st) begin
			if (frame_pos != POS_IDLE) restarts++;
			frame_crc  = crc8_shift(CRC_INIT, b);
			frame_data = '0;
			frame_pos  = POS_FIRST_DATA;
			return 1'b1;
		end
		if (frame_pos < POS_FIRST_DATA || frame_pos == POS_IDLE) return 1'b0;
		if (frame_pos <= POS_LAST_DATA) begin
			frame_crc  = crc8_shift(frame_crc, b);
			frame_data = {frame_data[DATA_W-9:0], b};
			frame_pos  = frame_pos + 3'd1;
			return 1'b1;
		end
		// crc byte: close the frame
		r = '0;
		r.ok = (frame_crc == b);
		if (r.ok) begin
			hprod  = 32'(frame_data[DATA_W-1:RAW_W]) * 32'd1000;
			tprod  = 32'(frame_data[RAW_W-1:0]) * 32'd2000;
			r.hum  = hprod[29:20];
			t      = int'(tprod >> 20) - 500;
			r.temp = t[TEMP_W-1:0];
			frames_ok++;
		end else begin
			frames_bad++;
		end
		readings_due.push_back(r);
		frame_pos = POS_IDLE;
		return 1'b1;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		errors++;
		if (errors <= 40)
			$display("ERROR t=%0t %s: got %0d, expected %0d", $realtime, what, got, want);
	endtask

	// one request on the byte side, with random idle cycles ahead of it
	task automatic send_byte(input logic [7:0] b, input logic st);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tuser  <= st;
		do @(posedge clk); while (!s_tready);
		if (decode_byte(b, st)) bytes_used++;
	endtask

	// whole frame with a correct or a corrupted crc byte
	task automatic send_frame(input logic [7:0] status, input logic [39:0] payload,
		input logic bad_crc);
		logic [7:0] crc;
		crc = crc8_shift(CRC_INIT, status);
		for (int i = 4; i >= 0; i--) crc = crc8_shift(crc, payload[i*8 +: 8]);
		if (bad_crc) crc = crc ^ 8'($urandom_range(1, 255));
		send_byte(status, 1'b1);
		for (int i = 4; i >= 0; i--) send_byte(payload[i*8 +: 8], 1'b0);
		send_byte(crc, 1'b0);
	endtask

	// hold off the byte side until every predicted reading has come out
	task automatic wait_for_results();
		int n;
		n = 0;
		s_tvalid <= 1'b0;
		while (readings_due.size() != 0 && n < 20000) begin
			@(posedge clk);
			n++;
		end
		if (readings_due.size() != 0) begin
			report_mismatch("readings never delivered", 0, readings_due.size());
			readings_due.delete();
		end
		repeat (4) @(posedge clk);
	endtask

	// random readiness on the result side
	always @(posedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	// compare every delivered reading with the oldest prediction
	always @(posedge clk) begin
		reading_t want;
		if (arst_n && m_tvalid && m_tready) begin
			readings_seen++;
			if (readings_due.size() == 0) begin
				report_mismatch("reading with none predicted", m_tdata[9:0], 0);
			end else begin
				want = readings_due.pop_front();
				if (m_tdata[9:0] != want.hum)
					report_mismatch("humidity_tenths", m_tdata[9:0], want.hum);
				if (m_tdata[21:10] != want.temp)
					report_mismatch("temperature_tenths", $signed(m_tdata[21:10]),
						$signed(want.temp));
				if (m_tuser != want.ok)
					report_mismatch("crc_ok", m_tuser, want.ok);
				if (m_tdata[23:22] != 2'b00)
					report_mismatch("tdata padding", m_tdata[23:22], 0);
			end
		end
	end

	// bytes outside any frame must be dropped
	task automatic test_idle_bytes_ignored();
		send_byte(8'hFF, 1'b0);
	endtask

	// humidity at full scale with temperature at its floor, then the reverse
	task automatic test_reading_extremes();
		send_frame(8'hFF, 40'hFF_FFF0_0000, 1'b0);
		send_frame(8'h00, 40'h00_000F_FFFF, 1'b0);
	endtask

	// restart on the crc byte, a crc mismatch, then a stray byte after the frame
	task automatic test_restart_and_bad_crc();
		send_byte(8'h5A, 1'b1);
		repeat (5) send_byte(8'($urandom), 1'b0);
		send_frame(8'hA5, 40'h01_2345_6789, 1'b1);
		send_byte(8'hC3, 1'b0);
	endtask

	// mostly good frames with random content, some broken ones and stray bytes
	task automatic test_random_traffic(input int s_pct, input int r_pct, input int count);
		int          first;
		int          sel;
		int          k;
		bit          paused;
		logic [39:0] payload;
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		first  = bytes_used;
		paused = 1'b0;
		while (bytes_used - first < count) begin
			if (!paused && bytes_used - first >= count / 2) begin
				wait_for_results();
				paused = 1'b1;
			end
			sel = $urandom_range(0, 99);
			if (sel < 75) begin
				// data bytes lean towards all zeros and all ones now and then
				for (int i = 0; i < 5; i++) begin
					k = $urandom_range(0, 9);
					payload[i*8 +: 8] = (k == 0) ? 8'h00 : (k == 1) ? 8'hFF : 8'($urandom);
				end
				send_frame(8'($urandom), payload, $urandom_range(0, 99) < 15);
			end else if (sel < 88) begin
				// truncated frame, cut off by whatever follows
				send_byte(8'($urandom), 1'b1);
				k = $urandom_range(0, 5);
				repeat (k) send_byte(8'($urandom), 1'b0);
			end else begin
				repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0);
			end
		end
	endtask

	initial begin
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tuser  <= 1'b0;
		m_tready <= 1'b0;
		errors = 0;
		bytes_used = 0;
		readings_seen = 0;
		frames_ok = 0;
		frames_bad = 0;
		restarts = 0;
		frame_pos  = POS_IDLE;
		frame_crc  = CRC_INIT;
		frame_data = '0;
		send_idle_pct = 14;
		recv_idle_pct = 85;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_idle_bytes_ignored();
		test_reading_extremes();
		test_restart_and_bad_crc();
		wait_for_results();

		test_random_traffic(14, 85, 540);
		wait_for_results();
		test_random_traffic(85, 14, 540);
		wait_for_results();
		test_random_traffic(0, 0, 540);
		wait_for_results();
		repeat (8) @(posedge clk);

		$display("run covered %0d frame bytes, %0d readings (%0d crc good, %0d crc bad)",
			bytes_used, readings_seen, frames_ok, frames_bad);
		$display("%0d frames were cut short by a new frame start, %0d mismatches",
			restarts, errors);
		if (errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/htfd_pkg.sv
hw/rtl/htfd_frame_tracker.sv
hw/rtl/htfd_scale.sv
hw/rtl/humidity_temp_frame_decoder.sv
tb/sv/tb_humidity_temp_frame_decoder.sv
